@@ rtl/colorkey_integer_sprite_scaler_core_macros.svh @@
// Assertion macros used by the sprite scaler write generator.
`ifndef COLORKEY_INTEGER_SPRITE_SCALER_CORE_MACROS_SVH
`define COLORKEY_INTEGER_SPRITE_SCALER_CORE_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define CSISC_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check that the consequent holds in the cycle after the antecedent.
`define CSISC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/csisc_pkg.sv @@
// Shared types and constants of the sprite scaler.
package csisc_pkg;

    localparam int COORD_BITS_DEF = 10;
    localparam int SRC_COORD_W    = 10;
    localparam int DST_W          = 13;
    localparam int PIX_W          = 16;
    localparam int ORIGIN_W       = 11;
    localparam int SPAN_W         = 2;
    localparam int QUEUE_DEPTH    = 2;
    localparam int CFG_ADDR_W     = 2;
    localparam int CFG_DATA_W     = 16;

    localparam logic [PIX_W-1:0] KEY_RESET = 16'h2104;

    typedef enum logic [1:0] {
        MODE_X2   = 2'd0,
        MODE_X3   = 2'd1,
        MODE_X4   = 2'd2,
        MODE_HALF = 2'd3
    } mode_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SCALE_MODE = 2'd0,
        REG_KEY_COLOR  = 2'd1,
        REG_ORIGIN_X   = 2'd2,
        REG_ORIGIN_Y   = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        mode_t                mode;
        logic [PIX_W-1:0]     key;
        logic [ORIGIN_W-1:0]  origin_x;
        logic [ORIGIN_W-1:0]  origin_y;
    } cfg_t;

    // One queued pixel: block corner, color and block side minus one.
    typedef struct packed {
        logic [DST_W-1:0]  base_x;
        logic [DST_W-1:0]  base_y;
        logic [PIX_W-1:0]  pixel;
        logic [SPAN_W-1:0] span;
    } job_t;

    localparam int JOB_W = $bits(job_t);

endpackage

@@ rtl/colorkey_integer_sprite_scaler_core.sv @@
// The first write beat of a pixel reaches m_tvalid after the pixel is queued and then registered.
// Throughput: one write beat per cycle while m_tready is high; a kept pixel makes
// 4, 9 or 16 write beats at 2x, 3x, 4x and one at half size, keyed or skipped pixels none.
// A two-entry queue lets the front end accept one pixel per cycle while it has room.
// Reset (aresetn, synchronous, active low) empties the queue, drops any pending beat
// and returns the registers to 2x mode, gray key 0x2104 and origin (0,0).
module colorkey_integer_sprite_scaler_core
    import csisc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Source pixel stream.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [39:0]           s_tdata,   // src_x[9:0], src_y[19:10], src_pixel[35:20], pad
    // Frame-buffer write stream.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [47:0]           m_tdata,   // dst_x[12:0], dst_y[25:13], dst_pixel[41:26], pad
    output logic                  m_tlast,   // final write of this source pixel
    // Register writes.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    mode_t               mode_reg;
    logic [PIX_W-1:0]    key_reg;
    logic [ORIGIN_W-1:0] ox_reg;
    logic [ORIGIN_W-1:0] oy_reg;
    cfg_t                cfg;

    logic                push;
    logic                pop;
    logic                full;
    logic                empty;
    job_t                push_job;
    job_t                head_job;
    logic [JOB_W-1:0]    head_bits;
    logic [DST_W-1:0]    dst_x;
    logic [DST_W-1:0]    dst_y;
    logic [PIX_W-1:0]    dst_pixel;

    // Registers are always writable; software must write them only while idle (not enforced here).
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_X2;
            key_reg  <= KEY_RESET;
            ox_reg   <= '0;
            oy_reg   <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_SCALE_MODE: mode_reg <= mode_t'(cfg_data[1:0]);
                REG_KEY_COLOR:  key_reg  <= cfg_data;
                REG_ORIGIN_X:   ox_reg   <= cfg_data[ORIGIN_W-1:0];
                REG_ORIGIN_Y:   oy_reg   <= cfg_data[ORIGIN_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.mode     = mode_reg;
    assign cfg.key      = key_reg;
    assign cfg.origin_x = ox_reg;
    assign cfg.origin_y = oy_reg;

    // Classify the pixel and compute the corner of its destination block.
    csisc_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .in_valid  (s_tvalid),
        .src_x     (s_tdata[9:0]),
        .src_y     (s_tdata[19:10]),
        .src_pixel (s_tdata[35:20]),
        .cfg       (cfg),
        .queue_full(full),
        .in_ready  (s_tready),
        .push      (push),
        .job       (push_job)
    );

    // Decouple acceptance from the multi-beat write walk.
    csisc_queue #(
        .WIDTH(JOB_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_data(push_job),
        .pop      (pop),
        .head_data(head_bits),
        .full     (full),
        .empty    (empty)
    );

    assign head_job = job_t'(head_bits);

    // Emit the block row by row, advancing only when the output register is empty or its beat is taken.
    csisc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head      (head_job),
        .empty     (empty),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .dst_x     (dst_x),
        .dst_y     (dst_y),
        .dst_pixel (dst_pixel),
        .last_write(m_tlast)
    );

    assign m_tdata = {6'd0, dst_pixel, dst_y, dst_x};

endmodule

@@ rtl/csisc_front.sv @@
// Front end: drop keyed or skipped pixels, compute block corner and size.
module csisc_front
    import csisc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                   in_valid,
    input  logic [SRC_COORD_W-1:0] src_x,
    input  logic [SRC_COORD_W-1:0] src_y,
    input  logic [PIX_W-1:0]       src_pixel,
    input  cfg_t                   cfg,
    input  logic                   queue_full,
    output logic                   in_ready,
    output logic                   push,
    output job_t                   job
);

    localparam int CW = (COORD_BITS < SRC_COORD_W) ? COORD_BITS : SRC_COORD_W;

    logic [DST_W-1:0]  sx;
    logic [DST_W-1:0]  sy;
    logic [DST_W-1:0]  off_x;
    logic [DST_W-1:0]  off_y;
    logic [SPAN_W-1:0] span;
    logic              keep;

    assign sx = DST_W'(src_x[CW-1:0]);
    assign sy = DST_W'(src_y[CW-1:0]);

    always_comb begin
        off_x = sx << 1;
        off_y = sy << 1;
        span  = SPAN_W'(1);
        unique case (cfg.mode)
            MODE_X2: begin
                off_x = sx << 1;
                off_y = sy << 1;
                span  = SPAN_W'(1);
            end
            MODE_X3: begin
                off_x = (sx << 1) + sx;
                off_y = (sy << 1) + sy;
                span  = SPAN_W'(2);
            end
            MODE_X4: begin
                off_x = sx << 2;
                off_y = sy << 2;
                span  = SPAN_W'(3);
            end
            MODE_HALF: begin
                off_x = sx >> 1;
                off_y = sy >> 1;
                span  = '0;
            end
            default: begin
                off_x = sx << 1;
                off_y = sy << 1;
                span  = SPAN_W'(1);
            end
        endcase
    end

    assign job.base_x = DST_W'(cfg.origin_x) + off_x;
    assign job.base_y = DST_W'(cfg.origin_y) + off_y;
    assign job.pixel  = src_pixel;
    assign job.span   = span;

    // Drop the key color, and odd positions when shrinking.
    assign keep = (src_pixel != cfg.key) &&
                  !((cfg.mode == MODE_HALF) && (sx[0] || sy[0]));

    assign in_ready = !queue_full;
    assign push     = in_valid && in_ready && keep;

endmodule

@@ rtl/csisc_queue.sv @@
// Small register queue between the front end and the write generator.
module csisc_queue
    import csisc_pkg::*;
#(
    parameter int WIDTH = JOB_W,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head_data,
    output logic             full,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0]  count_reg, count_next;

    assign full      = (count_reg == CNTW'(DEPTH));
    assign empty     = (count_reg == '0);
    assign head_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/csisc_back.sv @@
// Write generator: walk the block of one queued pixel, one beat per cycle while out_ready is high.
module csisc_back
    import csisc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  job_t             head,
    input  logic             empty,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [DST_W-1:0] dst_x,
    output logic [DST_W-1:0] dst_y,
    output logic [PIX_W-1:0] dst_pixel,
    output logic             last_write
);

`include "colorkey_integer_sprite_scaler_core_macros.svh"

    logic [SPAN_W-1:0] i_reg, i_next;
    logic [SPAN_W-1:0] j_reg, j_next;
    logic              valid_reg, valid_next;
    logic [DST_W-1:0]  x_reg;
    logic [DST_W-1:0]  y_reg;
    logic [PIX_W-1:0]  pix_reg;
    logic              last_reg;
    logic              load;
    logic              last_beat;

    assign load      = !empty && (!valid_reg || out_ready);
    assign last_beat = (i_reg == head.span) && (j_reg == head.span);
    assign pop       = load && last_beat;

    always_comb begin
        i_next     = i_reg;
        j_next     = j_reg;
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
            if (i_reg == head.span) begin
                i_next = '0;
                j_next = last_beat ? '0 : j_reg + 1'b1;
            end else begin
                i_next = i_reg + 1'b1;
            end
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            i_reg     <= '0;
            j_reg     <= '0;
            valid_reg <= 1'b0;
        end else begin
            i_reg     <= i_next;
            j_reg     <= j_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            x_reg    <= head.base_x + DST_W'(i_reg);
            y_reg    <= head.base_y + DST_W'(j_reg);
            pix_reg  <= head.pixel;
            last_reg <= last_beat;
        end
    end

    assign out_valid  = valid_reg;
    assign dst_x      = x_reg;
    assign dst_y      = y_reg;
    assign dst_pixel  = pix_reg;
    assign last_write = last_reg;

    // Counters rest at the block corner whenever no pixel is waiting.
    `CSISC_ASSERT_SAME(a_idle_corner, aclk, aresetn, empty, (i_reg == '0) && (j_reg == '0))
    // A beat that is not the last one moves the walk off the corner.
    `CSISC_ASSERT_NEXT(a_walk_moves, aclk, aresetn, load && !last_beat,
                       (i_reg != '0) || (j_reg != '0))
    // The last beat of a block carries the tlast mark.
    `CSISC_ASSERT_NEXT(a_pop_marks_last, aclk, aresetn, pop, valid_reg && last_reg)

endmodule
